// ===== hdl/chebyshev_2d_basis_eval_macros.svh =====
`ifndef CHEBYSHEV_2D_BASIS_EVAL_MACROS_SVH
`define CHEBYSHEV_2D_BASIS_EVAL_MACROS_SVH

// check sampled on clk, skipped while arst_n is low
`define C2BE_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// check that also holds while reset is applied
`define C2BE_ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/c2be_pkg.sv =====
package c2be_pkg;

	// external formats
	localparam int IO_FRAC  = 16;
	localparam int COORD_W  = 18;
	localparam int ORDER_W  = 4;
	localparam int VALUE_W  = 18;
	localparam int S_DATA_W = 48;
	localparam int M_DATA_W = 24;

	// axis select codes
	localparam logic AXIS_X = 1'b0;
	localparam logic AXIS_Y = 1'b1;

	typedef logic [ORDER_W-1:0] order_t;

	// sequencer to datapath controls
	typedef struct packed {
		logic load;      // capture a new item
		logic mul_en;    // start a multiply
		logic mul_fin;   // multiply the two axis terms
		logic mul_axis;  // axis of a recurrence multiply
		logic upd_en;    // recurrence update from the product
		logic upd_axis;  // axis of that update
		logic shift_en;  // form both shifted axis terms
		logic out_load;  // load the output register
	} ctrl_t;

endpackage

// ===== hdl/c2be_mul.sv =====
module c2be_mul #(
	parameter int W = 18
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [W-1:0]   a,
	input  logic signed [W-1:0]   b,
	output logic signed [2*W-1:0] prod_q
);

	// shared signed multiplier with registered product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

// ===== hdl/c2be_dp.sv =====
module c2be_dp #(
	parameter int FRAC_BITS = 16
) (
	input  logic                                 clk,
	input  c2be_pkg::ctrl_t                      ctl,
	input  logic signed [c2be_pkg::COORD_W-1:0]  x_coord,
	input  logic signed [c2be_pkg::COORD_W-1:0]  y_coord,
	input  c2be_pkg::order_t                     order_x,
	input  c2be_pkg::order_t                     order_y,
	input  logic                                 plus_x,
	input  logic                                 plus_y,
	output logic signed [c2be_pkg::VALUE_W-1:0]  basis_value
);
	import c2be_pkg::*;

	localparam int W       = FRAC_BITS + 2;
	localparam int PW      = 2 * W;
	localparam int NW      = W + 2;
	localparam int UP_IN   = (FRAC_BITS >= IO_FRAC) ? FRAC_BITS - IO_FRAC : 0;
	localparam int DN_IN   = (FRAC_BITS < IO_FRAC) ? IO_FRAC - FRAC_BITS : 0;
	localparam int RND_IN  = (1 << DN_IN) >> 1;
	localparam int CW      = (W + 2 > COORD_W + 1) ? W + 2 : COORD_W + 1;
	localparam int OUT_DN  = (FRAC_BITS > IO_FRAC) ? FRAC_BITS - IO_FRAC : 0;
	localparam int OUT_UP  = (FRAC_BITS < IO_FRAC) ? IO_FRAC - FRAC_BITS : 0;
	localparam int RND_OUT = (1 << OUT_DN) >> 1;
	localparam int RW      = (W + 2 > VALUE_W + 1) ? W + 2 : VALUE_W + 1;
	localparam int RND_REC = 1 << (FRAC_BITS - 2);
	localparam int RND_FIN = 1 << (FRAC_BITS - 1);

	localparam logic signed [W-1:0]  ONE     = W'(1) << FRAC_BITS;
	localparam logic signed [CW-1:0] ONE_C   = CW'(ONE);
	localparam logic signed [NW-1:0] ONE_N   = NW'(ONE);

	logic signed [W-1:0]      vx_q, vy_q, curx_q, cury_q, prevx_q, prevy_q;
	logic signed [W-1:0]      tx_q, ty_q;
	logic                     plusx_q, plusy_q, zerox_q, zeroy_q;
	logic signed [VALUE_W-1:0] out_q;
	logic signed [W-1:0]      mul_a, mul_b;
	logic signed [PW-1:0]     prod_q;
	logic signed [PW-1:0]     rnd_rec, rnd_fin;
	logic signed [NW-1:0]     rec_sh, rec_diff, fin_r;
	logic signed [W-1:0]      prev_sel, nxt, fin_sat, termx, termy;
	logic signed [RW-1:0]     out_e;

	// coordinate to internal format, saturated to one
	function automatic logic signed [W-1:0] coord_in(logic signed [COORD_W-1:0] c);
		logic signed [CW-1:0] e;
		e = CW'(c);
		e = (e <<< UP_IN) + CW'(RND_IN);
		e = e >>> DN_IN;
		if (e > ONE_C) begin
			e = ONE_C;
		end else if (e < -ONE_C) begin
			e = -ONE_C;
		end
		return W'(e);
	endfunction

	// saturate a widened value to one
	function automatic logic signed [W-1:0] sat_n(logic signed [NW-1:0] v);
		logic signed [NW-1:0] s;
		s = v;
		if (v > ONE_N) begin
			s = ONE_N;
		end else if (v < -ONE_N) begin
			s = -ONE_N;
		end
		return W'(s);
	endfunction

	// shifted axis term, (T+1)/2 or (1-T)/2 rounded half up, one for order zero
	function automatic logic signed [W-1:0] shift_term(logic signed [W-1:0] cur,
			logic plus, logic zero);
		logic signed [W:0] t;
		t = plus ? ((W+1)'(cur) + (W+1)'(ONE)) : ((W+1)'(ONE) - (W+1)'(cur));
		t = (t + (W+1)'(1)) >>> 1;
		return zero ? ONE : W'(t);
	endfunction

	// operand select for the shared multiplier
	always_comb begin
		if (ctl.mul_fin) begin
			mul_a = tx_q;
			mul_b = ty_q;
		end else if (ctl.mul_axis == AXIS_Y) begin
			mul_a = vy_q;
			mul_b = cury_q;
		end else begin
			mul_a = vx_q;
			mul_b = curx_q;
		end
	end

	c2be_mul #(.W(W)) u_mul (
		.clk    (clk),
		.en     (ctl.mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	// recurrence step: round(2*v*T) - Tprev, saturated
	always_comb begin
		prev_sel = (ctl.upd_axis == AXIS_Y) ? prevy_q : prevx_q;
		rnd_rec  = prod_q + PW'(RND_REC);
		rec_sh   = NW'(rnd_rec >>> (FRAC_BITS - 1));
		rec_diff = rec_sh - NW'(prev_sel);
		nxt      = sat_n(rec_diff);
	end

	// final product, rounding and output format
	always_comb begin
		rnd_fin = prod_q + PW'(RND_FIN);
		fin_r   = NW'(rnd_fin >>> FRAC_BITS);
		fin_sat = sat_n(fin_r);
		out_e   = RW'(fin_sat);
		out_e   = (out_e + RW'(RND_OUT)) >>> OUT_DN;
		out_e   = out_e <<< OUT_UP;
	end

	assign termx = shift_term(curx_q, plusx_q, zerox_q);
	assign termy = shift_term(cury_q, plusy_q, zeroy_q);

	// axis state and result registers
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			vx_q    <= coord_in(x_coord);
			vy_q    <= coord_in(y_coord);
			curx_q  <= coord_in(x_coord);
			cury_q  <= coord_in(y_coord);
			prevx_q <= ONE;
			prevy_q <= ONE;
			plusx_q <= plus_x;
			plusy_q <= plus_y;
			zerox_q <= (order_x == '0);
			zeroy_q <= (order_y == '0);
		end else if (ctl.upd_en) begin
			if (ctl.upd_axis == AXIS_Y) begin
				cury_q  <= nxt;
				prevy_q <= cury_q;
			end else begin
				curx_q  <= nxt;
				prevx_q <= curx_q;
			end
		end
		if (ctl.shift_en) begin
			tx_q <= termx;
			ty_q <= termy;
		end
		if (ctl.out_load) begin
			out_q <= VALUE_W'(out_e);
		end
	end

	assign basis_value = out_q;

endmodule

// ===== hdl/c2be_ctrl.sv =====
`include "chebyshev_2d_basis_eval_macros.svh"

module c2be_ctrl #(
	parameter int MAX_ORDER = 15
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  c2be_pkg::order_t  order_x,
	input  c2be_pkg::order_t  order_y,
	input  logic              m_tready,
	output logic              m_tvalid,
	output c2be_pkg::ctrl_t   ctl
);
	import c2be_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RUN   = 3'd1;
	localparam logic [2:0] S_SHIFT = 3'd2;
	localparam logic [2:0] S_FMUL  = 3'd3;
	localparam logic [2:0] S_FIN   = 3'd4;

	logic [2:0] state_q, state_nx;
	order_t     cntx_q, cnty_q, cnt_ph;
	logic       ph_q, pend_q, pend_axis_q, m_valid_q;
	logic       load, issue, run_done, out_load;

	// recurrence steps left for an order, clamped to the maximum
	function automatic order_t steps(order_t o);
		order_t n;
		n = (int'(o) > MAX_ORDER) ? order_t'(MAX_ORDER) : o;
		return (n == '0) ? '0 : n - 1'b1;
	endfunction

	// handshake and step decisions
	assign s_tready = (state_q == S_IDLE);
	assign load     = s_tvalid && s_tready;
	assign cnt_ph   = (ph_q == AXIS_Y) ? cnty_q : cntx_q;
	assign issue    = (state_q == S_RUN) && (cnt_ph != '0);
	assign run_done = (state_q == S_RUN) && (cntx_q == '0) && (cnty_q == '0);
	assign out_load = (state_q == S_FIN) && (!m_valid_q || m_tready);
	assign m_tvalid = m_valid_q;

	// controls to the datapath
	always_comb begin
		ctl.load     = load;
		ctl.mul_en   = issue || (state_q == S_FMUL);
		ctl.mul_fin  = (state_q == S_FMUL);
		ctl.mul_axis = ph_q;
		ctl.upd_en   = pend_q;
		ctl.upd_axis = pend_axis_q;
		ctl.shift_en = (state_q == S_SHIFT);
		ctl.out_load = out_load;
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			S_IDLE:  if (load) state_nx = S_RUN;
			S_RUN:   if (run_done) state_nx = S_SHIFT;
			S_SHIFT: state_nx = S_FMUL;
			S_FMUL:  state_nx = S_FIN;
			S_FIN:   if (out_load) state_nx = S_IDLE;
			default: state_nx = S_IDLE;
		endcase
	end

	// sequencer registers, axes take turns on the multiplier
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cntx_q      <= '0;
			cnty_q      <= '0;
			ph_q        <= AXIS_X;
			pend_q      <= 1'b0;
			pend_axis_q <= AXIS_X;
			m_valid_q   <= 1'b0;
		end else begin
			state_q     <= state_nx;
			pend_q      <= issue;
			pend_axis_q <= ph_q;
			if (load) begin
				cntx_q <= steps(order_x);
				cnty_q <= steps(order_y);
				ph_q   <= AXIS_X;
			end else begin
				if (issue && ph_q == AXIS_X) cntx_q <= cntx_q - 1'b1;
				if (issue && ph_q == AXIS_Y) cnty_q <= cnty_q - 1'b1;
				if (state_q == S_RUN) ph_q <= ~ph_q;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	`C2BE_ASSERT(a_idle_no_pend, s_tready |-> !pend_q, "product pending while idle")
	`C2BE_ASSERT(a_shift_clean, (state_q == S_SHIFT) |-> (cntx_q == '0 && cnty_q == '0 && !pend_q), "shift before recurrence finished")
	`C2BE_ASSERT(a_out_from_fin, $rose(m_valid_q) |-> ($past(state_q) == S_FIN), "result shown outside final step")
	`C2BE_ASSERT(a_run_one_mul, (ctl.mul_en && ctl.mul_fin) |-> !pend_q, "final multiply overlaps a recurrence update")
	`C2BE_ASSERT_RST(a_reset_idle, !arst_n |-> (state_q == S_IDLE && !m_valid_q), "not idle in reset")

endmodule

// ===== hdl/chebyshev_2d_basis_eval.sv =====
// channel  dir  tdata fields (lowest bit up)                           width
// s_axis   in   x_coord, y_coord, order_x, order_y, plus_x, plus_y      48
// m_axis   out  basis_value                                             24
//
// one item at a time; after accept the recurrence runs sx steps on x and sy
// on y, sx and sy the recurrence steps per axis (clamped order minus one, zero
// for order zero); then both shifted terms are formed, multiplied together,
// and the result is loaded. the two axes alternate on the shared multiplier,
// each recurrence step a multiply, then a subtract and saturate.
// s_tready is high only while idle; a result waiting in the output register
// does not block the next accept, only the final load of the next result.
// arst_n clears the sequencer and output valid; no clearing pass.
module chebyshev_2d_basis_eval #(
	parameter int MAX_ORDER = 15,
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// x_coord[17:0], y_coord[35:18], order_x[39:36], order_y[43:40],
	// plus_x[44], plus_y[45], zero fill [47:46]
	input  logic [c2be_pkg::S_DATA_W-1:0]   s_tdata,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// basis_value[17:0], zero fill [23:18]
	output logic [c2be_pkg::M_DATA_W-1:0]   m_tdata
);
	import c2be_pkg::*;

	ctrl_t                      ctl;
	logic signed [COORD_W-1:0]  x_coord, y_coord;
	order_t                     order_x, order_y;
	logic                       plus_x, plus_y;
	logic signed [VALUE_W-1:0]  basis_value;

	// unpack the input item
	assign x_coord = s_tdata[COORD_W-1:0];
	assign y_coord = s_tdata[2*COORD_W-1:COORD_W];
	assign order_x = s_tdata[2*COORD_W+ORDER_W-1:2*COORD_W];
	assign order_y = s_tdata[2*COORD_W+2*ORDER_W-1:2*COORD_W+ORDER_W];
	assign plus_x  = s_tdata[2*COORD_W+2*ORDER_W];
	assign plus_y  = s_tdata[2*COORD_W+2*ORDER_W+1];

	c2be_ctrl #(.MAX_ORDER(MAX_ORDER)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.order_x  (order_x),
		.order_y  (order_y),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.ctl      (ctl)
	);

	c2be_dp #(.FRAC_BITS(FRAC_BITS)) u_dp (
		.clk         (clk),
		.ctl         (ctl),
		.x_coord     (x_coord),
		.y_coord     (y_coord),
		.order_x     (order_x),
		.order_y     (order_y),
		.plus_x      (plus_x),
		.plus_y      (plus_y),
		.basis_value (basis_value)
	);

	// pack the result
	assign m_tdata = {{(M_DATA_W-VALUE_W){1'b0}}, basis_value};

endmodule
